[rtl/dmx512_receiver_htp_merge_unit_defines.svh]
// ----------------------------------------------------------------------------
// DMX512 HTP merge unit - assertion macros
// Concurrent assertion wrappers, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DMX512_RECEIVER_HTP_MERGE_UNIT_DEFINES_SVH
`define DMX512_RECEIVER_HTP_MERGE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Implication checked on the same clock edge.
`define DMXHTP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Precondition on one edge, consequence on the next.
`define DMXHTP_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`else

`define DMXHTP_ASSERT(label, prop, msg)
`define DMXHTP_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

[rtl/dmxhtp_pkg.sv]
// ----------------------------------------------------------------------------
// DMX512 HTP merge unit - package
// Shared sizes, codes, item types and the per-channel merge function.
// ----------------------------------------------------------------------------
package dmxhtp_pkg;

   localparam int SLOTS       = 512;
   localparam int LANES       = 4;
   localparam int READ_PORTS  = 2;
   localparam int LANE_W      = $clog2(LANES);
   localparam int SLOT_AW     = $clog2(SLOTS);
   localparam int SLOT_IW     = 10;
   localparam int START_W     = 9;
   localparam int TIMEOUT_W   = 17;
   localparam int LEVEL_W     = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 17'h10000;

   localparam logic [1:0] FUNC_SLOT  = 2'd0;
   localparam logic [1:0] FUNC_TICK  = 2'd1;
   localparam logic [1:0] FUNC_MERGE = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS = 2'd1;

   typedef enum logic [1:0] {
      PH_WAIT_BYTE  = 2'd0,
      PH_WAIT_BREAK = 2'd1,
      PH_WAIT_START = 2'd2,
      PH_DATA       = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      MG_IDLE   = 2'd0,
      MG_SECOND = 2'd1,
      MG_FINISH = 2'd2
   } merge_step_type;

   typedef struct packed {
      logic [1:0]         func;
      logic [LEVEL_W-1:0] rx_data;
      logic               frame_error;
      logic               overrun_error;
      logic [LEVEL_W-1:0] analog_0;
      logic [LEVEL_W-1:0] analog_1;
      logic [LEVEL_W-1:0] analog_2;
      logic [LEVEL_W-1:0] analog_3;
   } req_item_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level_0;
      logic [LEVEL_W-1:0] level_1;
      logic [LEVEL_W-1:0] level_2;
      logic [LEVEL_W-1:0] level_3;
      logic               frame_valid;
      logic [1:0]         rx_phase;
   } rsp_item_type;

   // Receiver status as seen by the merge sequencer and the result path.
   typedef struct packed {
      logic               frame_valid;
      phase_type          phase;
      logic [SLOT_IW-1:0] fill;
   } rx_status_type;

   // Highest-takes-precedence for one channel. Slots at or past the fill
   // count were never written since reset and are merged as zero.
   function automatic logic [LEVEL_W-1:0] merge_level(
      input logic               frame_valid,
      input logic [SLOT_IW-1:0] slot,
      input logic [SLOT_IW-1:0] fill,
      input logic [LEVEL_W-1:0] stored,
      input logic [LEVEL_W-1:0] analog
   );
      logic [LEVEL_W-1:0] result;
      result = analog;
      if (slot < SLOT_IW'(SLOTS) && slot < fill && frame_valid && stored > analog) begin
         result = stored;
      end
      return result;
   endfunction

endpackage

[rtl/dmxhtp_slot_store.sv]
// ----------------------------------------------------------------------------
// DMX512 HTP merge unit - slot store
// Slot byte memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module dmxhtp_slot_store (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [dmxhtp_pkg::SLOT_AW-1:0]      wr_addr,
   input  logic [dmxhtp_pkg::LEVEL_W-1:0]      wr_data,
   input  logic [dmxhtp_pkg::SLOT_AW-1:0]      rd_addr [dmxhtp_pkg::READ_PORTS],
   output logic [dmxhtp_pkg::LEVEL_W-1:0]      rd_data [dmxhtp_pkg::READ_PORTS]
);

   logic [dmxhtp_pkg::LEVEL_W-1:0] store_ff   [dmxhtp_pkg::SLOTS];
   logic [dmxhtp_pkg::LEVEL_W-1:0] rd_data_ff [dmxhtp_pkg::READ_PORTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      for (int p = 0; p < dmxhtp_pkg::READ_PORTS; p++) begin
         rd_data_ff[p] <= store_ff[rd_addr[p]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/dmxhtp_rx_ctrl.sv]
// ----------------------------------------------------------------------------
// DMX512 HTP merge unit - receiver control
// Break, start code and data state machine, inactivity timer and fill count.
// ----------------------------------------------------------------------------
module dmxhtp_rx_ctrl (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   slot_take,
   input  logic                                   tick_take,
   input  logic [dmxhtp_pkg::LEVEL_W-1:0]         rx_data,
   input  logic                                   frame_error,
   input  logic                                   overrun_error,
   input  logic [dmxhtp_pkg::START_W-1:0]         start_address,
   input  logic [dmxhtp_pkg::TIMEOUT_W-1:0]       timeout_ticks,
   output logic                                   wr_en,
   output logic [dmxhtp_pkg::SLOT_AW-1:0]         wr_addr,
   output logic [dmxhtp_pkg::LEVEL_W-1:0]         wr_data,
   output dmxhtp_pkg::rx_status_type              status,
   output dmxhtp_pkg::rx_status_type              status_next
);

   dmxhtp_pkg::phase_type                phase_ff, phase_in;
   logic [dmxhtp_pkg::SLOT_IW-1:0]       slot_index_ff, slot_index_in;
   logic [dmxhtp_pkg::SLOT_IW-1:0]       fill_ff, fill_in;
   logic                                 valid_ff, valid_in;
   logic [dmxhtp_pkg::TIMEOUT_W-1:0]     idle_count_ff, idle_count_in;
   logic                                 idle_running_ff, idle_running_in;

   logic [dmxhtp_pkg::SLOT_IW-1:0]       slot_next;
   logic [dmxhtp_pkg::SLOT_IW-1:0]       valid_mark;
   logic [dmxhtp_pkg::TIMEOUT_W-1:0]     idle_next;
   logic [dmxhtp_pkg::TIMEOUT_W-1:0]     limit;
   logic                                 data_zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dmxhtp_pkg::PH_WAIT_BREAK;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_index_ff   <= '0;
         fill_ff         <= '0;
         valid_ff        <= 1'b0;
         idle_count_ff   <= '0;
         idle_running_ff <= 1'b1;
      end else begin
         slot_index_ff   <= slot_index_in;
         fill_ff         <= fill_in;
         valid_ff        <= valid_in;
         idle_count_ff   <= idle_count_in;
         idle_running_ff <= idle_running_in;
      end
   end

   assign slot_next  = slot_index_ff + dmxhtp_pkg::SLOT_IW'(1);
   assign valid_mark = dmxhtp_pkg::SLOT_IW'(start_address)
                     + dmxhtp_pkg::SLOT_IW'(dmxhtp_pkg::LANES);
   assign idle_next  = idle_count_ff + dmxhtp_pkg::TIMEOUT_W'(1);
   assign limit      = (timeout_ticks == '0) ? dmxhtp_pkg::TIMEOUT_W'(1) : timeout_ticks;
   assign data_zero  = (rx_data == '0);

   assign wr_addr = slot_index_ff[dmxhtp_pkg::SLOT_AW-1:0];
   assign wr_data = rx_data;

   always_comb begin
      phase_in        = phase_ff;
      slot_index_in   = slot_index_ff;
      fill_in         = fill_ff;
      valid_in        = valid_ff;
      idle_count_in   = idle_count_ff;
      idle_running_in = idle_running_ff;
      wr_en           = 1'b0;

      if (slot_take) begin
         if (overrun_error) begin
            phase_in = dmxhtp_pkg::PH_WAIT_BYTE;
         end else begin
            case (phase_ff)
               dmxhtp_pkg::PH_WAIT_BYTE: begin
                  if (!frame_error) begin
                     phase_in = dmxhtp_pkg::PH_WAIT_BREAK;
                  end
               end
               dmxhtp_pkg::PH_WAIT_BREAK: begin
                  if (frame_error && data_zero) begin
                     phase_in = dmxhtp_pkg::PH_WAIT_START;
                  end
               end
               dmxhtp_pkg::PH_WAIT_START: begin
                  if (frame_error) begin
                     phase_in = dmxhtp_pkg::PH_WAIT_BYTE;
                  end else if (data_zero) begin
                     slot_index_in = '0;
                     phase_in      = dmxhtp_pkg::PH_DATA;
                  end else begin
                     phase_in = dmxhtp_pkg::PH_WAIT_BREAK;
                  end
               end
               dmxhtp_pkg::PH_DATA: begin
                  if (frame_error) begin
                     phase_in = data_zero ? dmxhtp_pkg::PH_WAIT_START
                                          : dmxhtp_pkg::PH_WAIT_BYTE;
                  end else begin
                     if (slot_index_ff < dmxhtp_pkg::SLOT_IW'(dmxhtp_pkg::SLOTS)) begin
                        wr_en = 1'b1;
                        if (slot_next > fill_ff) begin
                           fill_in = slot_next;
                        end
                     end
                     slot_index_in   = slot_next;
                     idle_count_in   = '0;
                     idle_running_in = 1'b1;
                     if (slot_next >= dmxhtp_pkg::SLOT_IW'(dmxhtp_pkg::SLOTS) ||
                         slot_next >= valid_mark) begin
                        valid_in = 1'b1;
                     end
                     if (slot_next >= dmxhtp_pkg::SLOT_IW'(dmxhtp_pkg::SLOTS)) begin
                        phase_in = dmxhtp_pkg::PH_WAIT_BREAK;
                     end
                  end
               end
               default: begin
                  phase_in = dmxhtp_pkg::PH_WAIT_BREAK;
               end
            endcase
         end
      end

      if (tick_take && idle_running_ff) begin
         idle_count_in = idle_next;
         if (idle_next >= limit) begin
            valid_in        = 1'b0;
            idle_running_in = 1'b0;
         end
      end
   end

   assign status.frame_valid      = valid_ff;
   assign status.phase            = phase_ff;
   assign status.fill             = fill_ff;
   assign status_next.frame_valid = valid_in;
   assign status_next.phase       = phase_in;
   assign status_next.fill        = fill_in;

endmodule

[rtl/dmxhtp_merge.sv]
// ----------------------------------------------------------------------------
// DMX512 HTP merge unit - merge sequencer
// Reads the addressed slots two at a time and forms the HTP levels.
// ----------------------------------------------------------------------------
module dmxhtp_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  dmxhtp_pkg::req_item_type            item,
   input  logic [dmxhtp_pkg::START_W-1:0]      start_address,
   input  dmxhtp_pkg::rx_status_type           status,
   input  logic [dmxhtp_pkg::LEVEL_W-1:0]      rd_data [dmxhtp_pkg::READ_PORTS],
   output logic [dmxhtp_pkg::SLOT_AW-1:0]      rd_addr [dmxhtp_pkg::READ_PORTS],
   output logic                                busy,
   output logic                                done,
   output logic [dmxhtp_pkg::LEVEL_W-1:0]      level [dmxhtp_pkg::LANES]
);

   dmxhtp_pkg::merge_step_type        step_ff, step_in;
   logic [dmxhtp_pkg::LEVEL_W-1:0]    analog_ff [dmxhtp_pkg::LANES];
   logic [dmxhtp_pkg::LEVEL_W-1:0]    level_ff  [dmxhtp_pkg::READ_PORTS];
   logic [dmxhtp_pkg::LEVEL_W-1:0]    level_new [dmxhtp_pkg::READ_PORTS];
   logic [dmxhtp_pkg::SLOT_IW-1:0]    slot_rd   [dmxhtp_pkg::READ_PORTS];
   logic [dmxhtp_pkg::SLOT_IW-1:0]    slot_cap  [dmxhtp_pkg::READ_PORTS];
   logic [dmxhtp_pkg::LANE_W-1:0]     lane_cap  [dmxhtp_pkg::READ_PORTS];
   logic                              rd_pair;
   logic                              cap_pair;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= dmxhtp_pkg::MG_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      step_in = step_ff;
      case (step_ff)
         dmxhtp_pkg::MG_IDLE: begin
            if (start) begin
               step_in = dmxhtp_pkg::MG_SECOND;
            end
         end
         dmxhtp_pkg::MG_SECOND: begin
            step_in = dmxhtp_pkg::MG_FINISH;
         end
         dmxhtp_pkg::MG_FINISH: begin
            step_in = dmxhtp_pkg::MG_IDLE;
         end
         default: begin
            step_in = dmxhtp_pkg::MG_IDLE;
         end
      endcase
   end

   assign busy = (step_ff != dmxhtp_pkg::MG_IDLE);
   assign done = (step_ff == dmxhtp_pkg::MG_FINISH);

   // The first pair is read on the accepting edge, the second on the edge ending MG_SECOND.
   assign rd_pair  = (step_ff == dmxhtp_pkg::MG_SECOND);
   assign cap_pair = (step_ff == dmxhtp_pkg::MG_FINISH);

   always_comb begin
      for (int p = 0; p < dmxhtp_pkg::READ_PORTS; p++) begin
         slot_rd[p]   = dmxhtp_pkg::SLOT_IW'(start_address)
                      + dmxhtp_pkg::SLOT_IW'(int'(rd_pair) * dmxhtp_pkg::READ_PORTS + p);
         rd_addr[p]   = slot_rd[p][dmxhtp_pkg::SLOT_AW-1:0];
         lane_cap[p]  = dmxhtp_pkg::LANE_W'(int'(cap_pair) * dmxhtp_pkg::READ_PORTS + p);
         slot_cap[p]  = dmxhtp_pkg::SLOT_IW'(start_address)
                      + dmxhtp_pkg::SLOT_IW'(lane_cap[p]);
         level_new[p] = dmxhtp_pkg::merge_level(status.frame_valid, slot_cap[p], status.fill,
                                                rd_data[p], analog_ff[lane_cap[p]]);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         analog_ff[0] <= item.analog_0;
         analog_ff[1] <= item.analog_1;
         analog_ff[2] <= item.analog_2;
         analog_ff[3] <= item.analog_3;
      end
      if (step_ff == dmxhtp_pkg::MG_SECOND) begin
         level_ff <= level_new;
      end
   end

   always_comb begin
      for (int k = 0; k < dmxhtp_pkg::LANES; k++) begin
         if (k < dmxhtp_pkg::READ_PORTS) begin
            level[k] = level_ff[k];
         end else begin
            level[k] = level_new[k - dmxhtp_pkg::READ_PORTS];
         end
      end
   end

endmodule

[rtl/dmx512_receiver_htp_merge_unit.sv]
// ----------------------------------------------------------------------------
// DMX512 receiver with HTP merge - top level
// Slot receiver, inactivity timer and four-channel highest-takes-precedence
// merge around a 512-byte slot store.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the req_ channel: a received UART slot, a timer tick
// or a merge request with four analog levels. Every item gives exactly one
// result item on the rsp_ channel, carrying the merged levels (zero unless
// the item is a merge), the frame-valid flag and the receiver phase.
// The csr_ channel writes start_address (index 0) and timeout_ticks
// (index 1); it is always ready, and writes to other indexes are ignored.
// Timing: a slot or tick item's result is in the output register the cycle
// after acceptance, and one such item can be taken every cycle while the
// output register is free or being emptied. A merge item reads its four
// slots through the store's two read ports a pair at a time, on the accepting
// edge and in MG_SECOND, and its result is loaded in MG_FINISH. The input is
// held off while the merge is busy, so this read sequence sets the merge rate.
// Reset clears the receiver state, the timer and the output valid flag. The
// store itself is not swept: a fill count marks how far it has been written,
// and slots beyond it read as zero, so the block is ready straight away.
// When the receiver stalls, the output register holds its item and req_ready
// falls until that item is taken.
// ----------------------------------------------------------------------------
`include "dmx512_receiver_htp_merge_unit_defines.svh"

module dmx512_receiver_htp_merge_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  dmxhtp_pkg::req_item_type               req_item,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output dmxhtp_pkg::rsp_item_type               rsp_item,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [dmxhtp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dmxhtp_pkg::CSR_DATA_W-1:0]      csr_data
);

   // Configuration registers.
   logic [dmxhtp_pkg::START_W-1:0]   start_address_ff;
   logic [dmxhtp_pkg::TIMEOUT_W-1:0] timeout_ticks_ff;

   // Output register.
   logic                             rsp_valid_ff, rsp_valid_in;
   dmxhtp_pkg::rsp_item_type         rsp_item_ff, rsp_item_in;

   logic                             req_fire;
   logic                             rsp_fire;
   logic                             rsp_load;
   logic                             slot_take;
   logic                             tick_take;
   logic                             merge_start;
   logic                             merge_busy;
   logic                             merge_done;

   logic                             store_wr_en;
   logic [dmxhtp_pkg::SLOT_AW-1:0]   store_wr_addr;
   logic [dmxhtp_pkg::LEVEL_W-1:0]   store_wr_data;
   logic [dmxhtp_pkg::SLOT_AW-1:0]   store_rd_addr [dmxhtp_pkg::READ_PORTS];
   logic [dmxhtp_pkg::LEVEL_W-1:0]   store_rd_data [dmxhtp_pkg::READ_PORTS];
   logic [dmxhtp_pkg::LEVEL_W-1:0]   merge_level   [dmxhtp_pkg::LANES];

   dmxhtp_pkg::rx_status_type        rx_status;
   dmxhtp_pkg::rx_status_type        rx_status_next;

   // Configuration writes are taken at once.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_address_ff <= '0;
         timeout_ticks_ff <= dmxhtp_pkg::TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            dmxhtp_pkg::CSR_START_ADDRESS: begin
               start_address_ff <= csr_data[dmxhtp_pkg::START_W-1:0];
            end
            dmxhtp_pkg::CSR_TIMEOUT_TICKS: begin
               timeout_ticks_ff <= csr_data[dmxhtp_pkg::TIMEOUT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // An item may enter when no merge is reading the store and the output
   // register is free or is being emptied in this cycle. Holding items off
   // during a merge also keeps later slot writes away from its reads.
   assign req_ready   = !merge_busy && (!rsp_valid_ff || rsp_ready);
   assign req_fire    = req_valid && req_ready;
   assign rsp_fire    = rsp_valid_ff && rsp_ready;
   assign slot_take   = req_fire && (req_item.func == dmxhtp_pkg::FUNC_SLOT);
   assign tick_take   = req_fire && (req_item.func == dmxhtp_pkg::FUNC_TICK);
   assign merge_start = req_fire && (req_item.func == dmxhtp_pkg::FUNC_MERGE);

   dmxhtp_rx_ctrl u_rx_ctrl (
      .clock         (clock),
      .reset         (reset),
      .slot_take     (slot_take),
      .tick_take     (tick_take),
      .rx_data       (req_item.rx_data),
      .frame_error   (req_item.frame_error),
      .overrun_error (req_item.overrun_error),
      .start_address (start_address_ff),
      .timeout_ticks (timeout_ticks_ff),
      .wr_en         (store_wr_en),
      .wr_addr       (store_wr_addr),
      .wr_data       (store_wr_data),
      .status        (rx_status),
      .status_next   (rx_status_next)
   );

   dmxhtp_slot_store u_slot_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_wr_addr),
      .wr_data (store_wr_data),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   dmxhtp_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .start         (merge_start),
      .item          (req_item),
      .start_address (start_address_ff),
      .status        (rx_status),
      .rd_data       (store_rd_data),
      .rd_addr       (store_rd_addr),
      .busy          (merge_busy),
      .done          (merge_done),
      .level         (merge_level)
   );

   // Slot and tick items report the status after their own update; a merge
   // changes no state, so it reports the status as it stands.
   assign rsp_load = (req_fire && !merge_start) || merge_done;

   always_comb begin
      if (merge_done) begin
         rsp_item_in.level_0     = merge_level[0];
         rsp_item_in.level_1     = merge_level[1];
         rsp_item_in.level_2     = merge_level[2];
         rsp_item_in.level_3     = merge_level[3];
         rsp_item_in.frame_valid = rx_status.frame_valid;
         rsp_item_in.rx_phase    = rx_status.phase;
      end else begin
         rsp_item_in.level_0     = '0;
         rsp_item_in.level_1     = '0;
         rsp_item_in.level_2     = '0;
         rsp_item_in.level_3     = '0;
         rsp_item_in.frame_valid = rx_status_next.frame_valid;
         rsp_item_in.rx_phase    = rx_status_next.phase;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // A new result never lands on one that has not been taken.
   `DMXHTP_ASSERT(a_rsp_no_overwrite, rsp_load |-> (!rsp_valid_ff || rsp_ready), "result overwritten before it was taken")
   // No slot is written while a merge is still reading the store.
   `DMXHTP_ASSERT(a_store_write_merge, store_wr_en |-> !merge_busy, "slot store written during a merge")
   // A merge holds the input off on the following cycle.
   `DMXHTP_ASSERT_NEXT(a_merge_holds_input, merge_start, merge_busy && !req_ready, "input not held off during a merge")
   // The fill count never passes the size of the store.
   `DMXHTP_ASSERT(a_fill_bound, rx_status.fill <= dmxhtp_pkg::SLOT_IW'(dmxhtp_pkg::SLOTS), "fill count past the store size")

endmodule
